>>> hdl/kmd_pkg.sv
// kmd_pkg: shared constants and types for the key matrix debounce core.
// Used by kmd_cfg, kmd_emit and key_matrix_debounce_note_events_core.
package kmd_pkg;

    // Message codes
    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;
    localparam logic [6:0] VEL_ON     = 7'd127;
    localparam logic [6:0] VEL_OFF    = 7'd0;

    // At most this many messages per scan
    localparam int MAX_MSG   = 16;
    localparam int MSG_CNT_W = 4;

    // Width of the raw level word
    localparam int LEVEL_BITS = 16;

    // Register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_NOTE_BASE     = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] REG_SCAN_INTERVAL = 2'd2;

    localparam logic [6:0]  NOTE_BASE_RST     = 7'd60;
    localparam logic [15:0] DEBOUNCE_RST      = 16'd20;
    localparam logic [7:0]  SCAN_INTERVAL_RST = 8'd5;

    typedef struct packed {
        logic [6:0]  note_base;
        logic [15:0] debounce_ms;
        logic [7:0]  scan_interval;
    } cfg_t;

endpackage

>>> hdl/kmd_cfg.sv
// kmd_cfg: APB-style register file (note base, debounce time, scan interval).
// Depends on kmd_pkg.
module kmd_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmd_pkg::DATA_W-1:0]  pwdata,
    output logic [kmd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output kmd_pkg::cfg_t               cfg
);

    kmd_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.note_base     <= kmd_pkg::NOTE_BASE_RST;
            cfg_reg.debounce_ms   <= kmd_pkg::DEBOUNCE_RST;
            cfg_reg.scan_interval <= kmd_pkg::SCAN_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                kmd_pkg::REG_NOTE_BASE:     cfg_reg.note_base     <= pwdata[6:0];
                kmd_pkg::REG_DEBOUNCE:      cfg_reg.debounce_ms   <= pwdata[15:0];
                kmd_pkg::REG_SCAN_INTERVAL: cfg_reg.scan_interval <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            kmd_pkg::REG_NOTE_BASE:     prdata = {25'd0, cfg_reg.note_base};
            kmd_pkg::REG_DEBOUNCE:      prdata = {16'd0, cfg_reg.debounce_ms};
            kmd_pkg::REG_SCAN_INTERVAL: prdata = {24'd0, cfg_reg.scan_interval};
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> hdl/kmd_emit.sv
// kmd_emit: holds the flipped-key mask of one scan and drains it, lowest key
// first, into the output register. Depends on kmd_pkg.
module kmd_emit
#(
    parameter int NKEYS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [NKEYS-1:0] load_mask,
    input  logic [NKEYS-1:0] key_pressed,
    input  logic [6:0]       note_base,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       status_byte,
    output logic [6:0]       note_number,
    output logic [6:0]       velocity,
    output logic             last_event
);

    logic [NKEYS-1:0]              pend_reg, pend_next;
    logic [kmd_pkg::MSG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    status_reg;
    logic [6:0]                    note_reg;
    logic [6:0]                    vel_reg;
    logic                          last_reg;

    logic             pend_any;
    logic             fire;
    logic             last;
    logic             sel_pressed;
    logic [NKEYS-1:0] sel_oh;
    logic [NKEYS-1:0] rest;
    logic [6:0]       key_off;

    assign pend_any    = |pend_reg;
    assign fire        = pend_any && (!out_valid_reg || !out_stall);
    // isolate the lowest pending key
    assign sel_oh      = pend_reg & (~pend_reg + NKEYS'(1));
    assign rest        = pend_reg & ~sel_oh;
    assign sel_pressed = |(sel_oh & key_pressed);
    assign last        = (rest == '0) ||
                         (cnt_reg == kmd_pkg::MSG_CNT_W'(kmd_pkg::MAX_MSG - 1));
    assign free        = !pend_any || (fire && last);

    always_comb
    begin
        key_off = '0;
        for (int k = 0; k < NKEYS; k++)
        begin
            if (sel_oh[k])
            begin
                key_off = key_off | 7'(k);
            end
        end
    end

    always_comb
    begin
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            pend_next      = last ? '0 : rest;
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        if (load)
        begin
            pend_next = load_mask;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= sel_pressed ? kmd_pkg::STATUS_ON : kmd_pkg::STATUS_OFF;
            note_reg   <= note_base + key_off;
            vel_reg    <= sel_pressed ? kmd_pkg::VEL_ON : kmd_pkg::VEL_OFF;
            last_reg   <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status_byte = status_reg;
    assign note_number = note_reg;
    assign velocity    = vel_reg;
    assign last_event  = last_reg;

    // a new scan mask never lands on one still draining
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("scan mask loaded while previous scan still pending");

    // note on always carries full velocity, note off zero
    a_vel_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((status_reg == kmd_pkg::STATUS_ON) == (vel_reg == kmd_pkg::VEL_ON)))
        else $error("status and velocity disagree");

    // sixteenth message of a scan closes it
    a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cnt_reg == kmd_pkg::MSG_CNT_W'(kmd_pkg::MAX_MSG - 1)) |=> last_reg)
        else $error("message cap reached without last_event");

endmodule

>>> hdl/key_matrix_debounce_note_events_core.sv
// key_matrix_debounce_note_events_core: top level of the key matrix scanner.
// Depends on kmd_pkg, kmd_cfg and kmd_emit.
//
// Usage:
//  - Input channel (in_valid/in_stall): one request is one full matrix scan:
//    row_levels (bit column*ROWS+row, 0 = pressed), now_ms and link_up.
//  - Output channel (out_valid/out_stall): one request per flipped key, in
//    row-major order, note on/off with velocity; last_event marks the final
//    message of a scan. Scans that are too early, have no flips, or arrive
//    with the link down give no messages.
//  - Registers over the APB-style port: note base (0x0), debounce_ms (0x4),
//    scan_interval (0x8). Write them only while the core is idle.
// Timing:
//  - A scan is registered at the input and evaluated once the emitter is
//    free (per-key 32-bit age compares run in parallel); its flips pass
//    through the pending-key mask register into the output register.
//  - Messages drain one per cycle from the pending-key mask unless the
//    output stalls, at most 16 per scan.
//  - The next scan is evaluated in the cycle the last message of the
//    previous one moves into the output register.
//  - Reset releases all keys, clears their flip times and the last scan
//    time, and loads register defaults. Output stall holds the output
//    register and backs up into in_stall once the mask cannot drain.
module key_matrix_debounce_note_events_core
#(
    parameter int ROWS = 4,
    parameter int COLS = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmd_pkg::DATA_W-1:0]  pwdata,
    output logic [kmd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // scan input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [15:0]                 row_levels,
    input  logic [31:0]                 now_ms,
    input  logic                        link_up,
    // note messages
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  status_byte,
    output logic [6:0]                  note_number,
    output logic [6:0]                  velocity,
    output logic                        last_event
);

    localparam int NKEYS = ROWS * COLS;

    kmd_pkg::cfg_t cfg;

    // input register
    logic        in_valid_reg;
    logic [15:0] levels_reg;
    logic [31:0] now_reg;
    logic        link_reg;

    // debounce state
    logic [NKEYS-1:0] key_pressed_reg;
    logic [31:0]      flip_time_reg [NKEYS];
    logic [31:0]      scan_stamp_reg;

    logic             emit_free;
    logic             advance;
    logic [31:0]      since_scan;
    logic             scan_ok;
    logic [NKEYS-1:0] lvl_pressed;
    logic [NKEYS-1:0] flip;

    kmd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = in_valid_reg && !emit_free;
    assign advance  = in_valid_reg && emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            levels_reg <= row_levels;
            now_reg    <= now_ms;
            link_reg   <= link_up;
        end
    end

    // scan rate gate: wrapped age of the last accepted scan
    assign since_scan = now_reg - scan_stamp_reg;
    assign scan_ok    = since_scan >= {24'd0, cfg.scan_interval};

    // per-key level decode; keys past the 16 level bits read as released
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < COLS; c++)
        begin : g_col
            localparam int KEY = r * COLS + c;
            localparam int LVL = c * ROWS + r;
            logic [31:0] since_flip;

            if (LVL < kmd_pkg::LEVEL_BITS)
            begin : g_lvl
                assign lvl_pressed[KEY] = !levels_reg[LVL];
            end
            else
            begin : g_none
                assign lvl_pressed[KEY] = 1'b0;
            end

            assign since_flip = now_reg - flip_time_reg[KEY];
            assign flip[KEY]  = scan_ok && (lvl_pressed[KEY] != key_pressed_reg[KEY]) &&
                                (since_flip > {16'd0, cfg.debounce_ms});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pressed_reg <= '0;
            scan_stamp_reg  <= '0;
            for (int k = 0; k < NKEYS; k++)
            begin
                flip_time_reg[k] <= '0;
            end
        end
        else if (advance && scan_ok)
        begin
            scan_stamp_reg  <= now_reg;
            key_pressed_reg <= key_pressed_reg ^ flip;
            for (int k = 0; k < NKEYS; k++)
            begin
                if (flip[k])
                begin
                    flip_time_reg[k] <= now_reg;
                end
            end
        end
    end

    // link down: state still moves, nothing is queued
    kmd_emit #(.NKEYS(NKEYS)) u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && link_reg),
        .load_mask   (flip),
        .key_pressed (key_pressed_reg),
        .note_base   (cfg.note_base),
        .free        (emit_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status_byte (status_byte),
        .note_number (note_number),
        .velocity    (velocity),
        .last_event  (last_event)
    );

endmodule
